/* hdl/order_book_match_engine_macros.svh */
// Assertion macros for the order book match engine.
`ifndef ORDER_BOOK_MATCH_ENGINE_MACROS_SVH
`define ORDER_BOOK_MATCH_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OBME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define OBME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OBME_ASSERT(lbl, prop, msg)

`define OBME_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/obme_pkg.sv */
// Shared types and constants for the order book match engine.
package obme_pkg;

  localparam int unsigned QtyW   = 16;
  localparam int unsigned PriceW = 20;
  localparam int unsigned CountW = 7;
  localparam int unsigned InW    = 40;
  localparam int unsigned OutW   = 32;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic              side;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [PriceW-1:0] price;
  } cand_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic [CountW-1:0] count;
    logic              full;
    logic [PriceW-1:0] price;
    logic              matched;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

endpackage

/* hdl/obme_cell.sv */
// One book slot: holds an entry, updates the running best match, shifts or loads.
module obme_cell #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  obme_pkg::entry_t order_i,
  input  obme_pkg::cand_t cand_i,
  input  logic [IdxW-1:0] cand_idx_i,
  output obme_pkg::cand_t cand_o,
  output logic [IdxW-1:0] cand_idx_o,
  input  logic            shift_i,
  input  obme_pkg::entry_t next_i,
  input  logic            load_i,
  output obme_pkg::entry_t entry_o
);
  import obme_pkg::*;

  entry_t          entry_q, entry_d;
  cand_t           cand_q, cand_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            take;

  always_comb begin
    take = valid_i && (entry_q.side != order_i.side) && (entry_q.qty == order_i.qty) &&
           (!cand_i.found ||
            (order_i.side && (entry_q.price < cand_i.price)) ||
            (!order_i.side && (entry_q.price > cand_i.price)));
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.price = entry_q.price;
      idx_d        = IdxW'(CellIdx);
    end else begin
      cand_d = cand_i;
      idx_d  = cand_idx_i;
    end
  end

  always_comb begin
    if (load_i) begin
      entry_d = order_i;
    end else if (shift_i) begin
      entry_d = next_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      idx_q  <= '0;
    end else begin
      cand_q <= cand_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = idx_q;
  assign entry_o    = entry_q;

endmodule

/* hdl/order_book_match_engine.sv */
// A new order is accepted only in idle; the best-match search then walks the slot
// chain one slot per cycle, and the commit state removes the match or appends the
// order if there is room, waiting while an earlier result is not yet taken.
// Reset (async, active low) empties the book and drops any pending result;
// slot contents are not cleared, only the entry count.
`include "order_book_match_engine_macros.svh"

module order_book_match_engine #(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] order_side, [16:1] order_qty, [36:17] order_price
  input  logic [obme_pkg::InW-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] matched, [20:1] matched_price, [21] book_full, [28:22] resting_count
  output logic [obme_pkg::OutW-1:0] m_axis_tdata
);
  import obme_pkg::*;

  localparam int unsigned IdxW = $clog2(BOOK_DEPTH);
  localparam int unsigned CntW = $clog2(BOOK_DEPTH + 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic [CntW-1:0] count_q, count_d;
  entry_t          order_q;
  logic            out_valid_q, out_valid_d;
  res_t            out_data_q, out_data_d;

  logic            accept, commit_go, found, book_full, shift_all, append;
  logic [IdxW-1:0] best_idx;
  cand_t           best;

  cand_t           cand_chain [BOOK_DEPTH+1];
  logic [IdxW-1:0] idx_chain  [BOOK_DEPTH+1];
  entry_t          ent        [BOOK_DEPTH];

  assign cand_chain[0] = '0;
  assign idx_chain[0]  = '0;
  assign best          = cand_chain[BOOK_DEPTH];
  assign best_idx      = idx_chain[BOOK_DEPTH];
  assign found         = best.found;
  assign book_full     = (count_q == CntW'(BOOK_DEPTH));

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    entry_t next_ent;
    if (i == BOOK_DEPTH - 1) begin : g_last
      assign next_ent = ent[i];
    end else begin : g_mid
      assign next_ent = ent[i+1];
    end
    obme_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (CntW'(i) < count_q),
      .order_i    (order_q),
      .cand_i     (cand_chain[i]),
      .cand_idx_i (idx_chain[i]),
      .cand_o     (cand_chain[i+1]),
      .cand_idx_o (idx_chain[i+1]),
      .shift_i    (shift_all && (IdxW'(i) >= best_idx)),
      .next_i     (next_ent),
      .load_i     (append && (count_q == CntW'(i))),
      .entry_o    (ent[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_SEARCH;
      ST_SEARCH: if (sweep_q == IdxW'(BOOK_DEPTH - 1)) state_d = ST_COMMIT;
      ST_COMMIT: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready = 1'b0;
    commit_go     = 1'b0;
    sweep_d       = '0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SEARCH: sweep_d = sweep_q + IdxW'(1);
      ST_COMMIT: commit_go = !out_valid_q || m_axis_tready;
      default:   s_axis_tready = 1'b0;
    endcase
    accept    = s_axis_tvalid && s_axis_tready;
    shift_all = commit_go && found;
    append    = commit_go && !found && !book_full;

    count_d = count_q;
    if (shift_all) begin
      count_d = count_q - CntW'(1);
    end else if (append) begin
      count_d = count_q + CntW'(1);
    end

    out_data_d.pad     = '0;
    out_data_d.count   = CountW'(count_d);
    out_data_d.full    = !found && book_full;
    out_data_d.price   = found ? best.price : '0;
    out_data_d.matched = found;

    out_valid_d = out_valid_q;
    if (commit_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sweep_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      order_q.side  <= s_axis_tdata[0];
      order_q.qty   <= s_axis_tdata[16:1];
      order_q.price <= s_axis_tdata[36:17];
    end
    if (commit_go) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `OBME_ASSERT(a_count_range, count_q <= CntW'(BOOK_DEPTH), "entry count above depth")
  `OBME_ASSERT(a_match_not_full, out_valid_q && out_data_q.matched |-> !out_data_q.full,
               "match flagged as full")
  `OBME_ASSERT_NEXT(a_accept_search, accept, state_q == ST_SEARCH,
                    "accepted item did not start a search")
  `OBME_ASSERT_NEXT(a_remove_dec, shift_all, count_q == $past(count_q) - CntW'(1),
                    "removal did not shrink the book")

endmodule
